/* hw/rtl/ptwa_pkg.sv */
package ptwa_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Command queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Packet checks
    localparam logic [7:0]  PROTO_DISCOVERY = 8'd253;
    localparam logic [7:0]  TYPE_HELLO      = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd20;

    // Request modes
    localparam logic [1:0] MODE_PACKET = 2'd0;
    localparam logic [1:0] MODE_SWEEP  = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Register index (paddr[2])
    localparam logic REG_TIMEOUT = 1'b0;

    typedef enum logic [2:0] {
        ST_IGNORED    = 3'd0,
        ST_NEW        = 3'd1,
        ST_REFRESHED  = 3'd2,
        ST_FULL       = 3'd3,
        ST_EVICTED    = 3'd4,
        ST_SWEEP_DONE = 3'd5,
        ST_QUERY      = 3'd6,
        ST_NO_PEERS   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        OP_IGNORE = 2'd0,
        OP_HELLO  = 2'd1,
        OP_SWEEP  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    // Classified request handed from front to back
    typedef struct packed {
        op_t         op;
        logic [31:0] now;
        logic [31:0] addr;
    } cmd_t;

endpackage

/* hw/rtl/ptwa_front.sv */
module ptwa_front (
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [31:0]       now_seconds,
    input  logic [31:0]       source_address,
    input  logic [7:0]        ip_protocol,
    input  logic [3:0]        header_words,
    input  logic [15:0]       packet_length,
    input  logic [7:0]        message_type,
    output logic              push_valid,
    input  logic              push_ready,
    output ptwa_pkg::cmd_t    push_cmd
);

    logic [6:0] min_len;
    logic       pkt_ok;

    // Header sanity: protocol, minimum length, hello type
    assign min_len = {1'b0, header_words, 2'b00} + 7'd8;
    assign pkt_ok  = (ip_protocol == ptwa_pkg::PROTO_DISCOVERY)
                  && (packet_length >= {9'b0, min_len})
                  && (message_type == ptwa_pkg::TYPE_HELLO);

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    // Classify the request
    always_comb
    begin
        push_cmd.now  = now_seconds;
        push_cmd.addr = source_address;
        unique case (mode)
            ptwa_pkg::MODE_PACKET: push_cmd.op = pkt_ok ? ptwa_pkg::OP_HELLO
                                                        : ptwa_pkg::OP_IGNORE;
            ptwa_pkg::MODE_SWEEP:  push_cmd.op = ptwa_pkg::OP_SWEEP;
            ptwa_pkg::MODE_QUERY:  push_cmd.op = ptwa_pkg::OP_QUERY;
            default:               push_cmd.op = ptwa_pkg::OP_IGNORE;
        endcase
    end

endmodule

/* hw/rtl/ptwa_queue.sv */
module ptwa_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  ptwa_pkg::cmd_t    push_cmd,
    output logic              pop_valid,
    input  logic              pop,
    output ptwa_pkg::cmd_t    pop_cmd
);

    ptwa_pkg::cmd_t                     slot_reg [ptwa_pkg::QUEUE_DEPTH];
    logic [ptwa_pkg::QPTR_W-1:0]        wptr_reg;
    logic [ptwa_pkg::QPTR_W-1:0]        rptr_reg;
    logic [ptwa_pkg::QCNT_W-1:0]        cnt_reg;
    logic                               do_push;
    logic                               do_pop;

    assign push_ready = (cnt_reg != ptwa_pkg::QCNT_W'(ptwa_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= push_cmd;
    end

endmodule

/* hw/rtl/ptwa_back.sv */
module ptwa_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       evict_timeout,
    input  logic              q_valid,
    output logic              q_pop,
    input  ptwa_pkg::cmd_t    q_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [31:0]       peer_address,
    output logic [15:0]       round_tag,
    output logic              last_of_run
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PACKET,
        S_SWEEP,
        S_QUERY
    } state_t;

    state_t                          state_reg, state_next;
    logic [ptwa_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [ptwa_pkg::CNT_W-1:0]      ptr_reg, ptr_next;
    logic [ptwa_pkg::CNT_W-1:0]      wr_reg, wr_next;
    logic [15:0]                     qid_reg, qid_next;
    logic                            ov_reg, ov_next;
    ptwa_pkg::status_t               ost_reg, ost_next;
    logic [31:0]                     oaddr_reg, oaddr_next;
    logic [15:0]                     otid_reg, otid_next;
    logic                            olast_reg, olast_next;
    ptwa_pkg::cmd_t                  cmd_reg, cmd_next;

    logic [31:0]                     addr_mem [ptwa_pkg::TABLE_DEPTH];
    logic [31:0]                     last_mem [ptwa_pkg::TABLE_DEPTH];

    logic                            out_free;
    logic [ptwa_pkg::TABLE_DEPTH-1:0] sel;
    logic                            any_hit;
    logic [ptwa_pkg::IDX_W-1:0]      rd_idx;
    logic [ptwa_pkg::IDX_W-1:0]      wr_idx;
    logic [31:0]                     rd_addr;
    logic [31:0]                     rd_last;
    logic [31:0]                     age;
    logic                            expired;
    logic                            ptr_at_end;
    logic [ptwa_pkg::CNT_W-1:0]      ptr_inc;
    logic                            ins_en;
    logic                            ref_en;
    logic                            cpy_en;

    assign out_free     = !ov_reg || out_ready;
    assign out_valid    = ov_reg;
    assign status       = ost_reg;
    assign peer_address = oaddr_reg;
    assign round_tag    = otid_reg;
    assign last_of_run  = olast_reg;

    // Parallel lookup over live entries, first hit wins
    always_comb
    begin
        logic found;
        logic hit;
        found = 1'b0;
        for (int i = 0; i < ptwa_pkg::TABLE_DEPTH; i++)
        begin
            hit    = (ptwa_pkg::CNT_W'(i) < count_reg) && (addr_mem[i] == cmd_reg.addr);
            sel[i] = hit && !found;
            found  = found || hit;
        end
        any_hit = found;
    end

    // Walk pointer read port and age check
    assign rd_idx     = ptr_reg[ptwa_pkg::IDX_W-1:0];
    assign wr_idx     = wr_reg[ptwa_pkg::IDX_W-1:0];
    assign rd_addr    = addr_mem[rd_idx];
    assign rd_last    = last_mem[rd_idx];
    assign age        = cmd_reg.now - rd_last;
    assign expired    = age > {16'b0, evict_timeout};
    assign ptr_at_end = (ptr_reg == count_reg);
    assign ptr_inc    = ptr_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        wr_next    = wr_reg;
        qid_next   = qid_reg;
        cmd_next   = cmd_reg;
        ov_next    = ov_reg && !out_ready;
        ost_next   = ost_reg;
        oaddr_next = oaddr_reg;
        otid_next  = otid_reg;
        olast_next = olast_reg;
        q_pop      = 1'b0;
        ins_en     = 1'b0;
        ref_en     = 1'b0;
        cpy_en     = 1'b0;

        if (out_free)
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        q_pop    = 1'b1;
                        cmd_next = q_cmd;
                        unique case (q_cmd.op)
                            ptwa_pkg::OP_IGNORE:
                            begin
                                ov_next    = 1'b1;
                                ost_next   = ptwa_pkg::ST_IGNORED;
                                oaddr_next = '0;
                                otid_next  = '0;
                                olast_next = 1'b1;
                            end
                            ptwa_pkg::OP_HELLO:
                                state_next = S_PACKET;
                            ptwa_pkg::OP_SWEEP:
                            begin
                                ptr_next   = '0;
                                wr_next    = '0;
                                state_next = S_SWEEP;
                            end
                            ptwa_pkg::OP_QUERY:
                            begin
                                if (count_reg == '0)
                                begin
                                    ov_next    = 1'b1;
                                    ost_next   = ptwa_pkg::ST_NO_PEERS;
                                    oaddr_next = '0;
                                    otid_next  = '0;
                                    olast_next = 1'b1;
                                end
                                else
                                begin
                                    qid_next   = qid_reg + 16'd1;
                                    ptr_next   = '0;
                                    state_next = S_QUERY;
                                end
                            end
                        endcase
                    end
                end

                S_PACKET:
                begin
                    ov_next    = 1'b1;
                    oaddr_next = cmd_reg.addr;
                    otid_next  = '0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                    priority if (any_hit)
                    begin
                        ref_en   = 1'b1;
                        ost_next = ptwa_pkg::ST_REFRESHED;
                    end
                    else if (count_reg == ptwa_pkg::CNT_W'(ptwa_pkg::TABLE_DEPTH))
                    begin
                        ost_next = ptwa_pkg::ST_FULL;
                    end
                    else
                    begin
                        ins_en     = 1'b1;
                        count_next = count_reg + 1'b1;
                        ost_next   = ptwa_pkg::ST_NEW;
                    end
                end

                S_SWEEP:
                begin
                    priority if (ptr_at_end)
                    begin
                        count_next = wr_reg;
                        ov_next    = 1'b1;
                        ost_next   = ptwa_pkg::ST_SWEEP_DONE;
                        oaddr_next = '0;
                        otid_next  = '0;
                        olast_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (expired)
                    begin
                        ov_next    = 1'b1;
                        ost_next   = ptwa_pkg::ST_EVICTED;
                        oaddr_next = rd_addr;
                        otid_next  = '0;
                        olast_next = 1'b0;
                        ptr_next   = ptr_inc;
                    end
                    else
                    begin
                        cpy_en   = 1'b1;
                        wr_next  = wr_reg + 1'b1;
                        ptr_next = ptr_inc;
                    end
                end

                S_QUERY:
                begin
                    ov_next    = 1'b1;
                    ost_next   = ptwa_pkg::ST_QUERY;
                    oaddr_next = rd_addr;
                    otid_next  = qid_reg;
                    olast_next = (ptr_inc == count_reg);
                    ptr_next   = ptr_inc;
                    if (ptr_inc == count_reg)
                        state_next = S_IDLE;
                end
            endcase
        end
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            wr_reg    <= '0;
            qid_reg   <= '0;
            ov_reg    <= 1'b0;
            ost_reg   <= ptwa_pkg::ST_IGNORED;
            oaddr_reg <= '0;
            otid_reg  <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            wr_reg    <= wr_next;
            qid_reg   <= qid_next;
            ov_reg    <= ov_next;
            ost_reg   <= ost_next;
            oaddr_reg <= oaddr_next;
            otid_reg  <= otid_next;
            olast_reg <= olast_next;
        end
    end

    // Current request
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // Table storage: head insert shifts, refresh in place, sweep compaction
    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            for (int i = 1; i < ptwa_pkg::TABLE_DEPTH; i++)
            begin
                addr_mem[i] <= addr_mem[i-1];
                last_mem[i] <= last_mem[i-1];
            end
            addr_mem[0] <= cmd_reg.addr;
            last_mem[0] <= cmd_reg.now;
        end
        if (ref_en)
        begin
            for (int i = 0; i < ptwa_pkg::TABLE_DEPTH; i++)
            begin
                if (sel[i])
                    last_mem[i] <= cmd_reg.now;
            end
        end
        if (cpy_en)
        begin
            addr_mem[wr_idx] <= rd_addr;
            last_mem[wr_idx] <= rd_last;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ptwa_pkg::CNT_W'(ptwa_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (wr_reg <= ptr_reg && ptr_reg <= count_reg))
        else $error("sweep write pointer passed read pointer");

    a_query_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QUERY) |-> (ptr_reg < count_reg))
        else $error("query walk beyond live entries");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && state_reg == S_IDLE))
        else $error("pop from empty queue or while busy");

    a_qid_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(qid_reg) |-> ($past(state_reg) == S_IDLE && state_reg == S_QUERY))
        else $error("transaction id moved outside query start");

endmodule

/* hw/rtl/peer_table_with_aging.sv */
// Peer table with aging.
// Requests enter on in_valid/in_ready with mode and the packet fields;
// results leave on out_valid/out_ready, one request producing 1 to 17
// results, the final one flagged by last_of_run.
// The front classifies each request (packet checks) in the accept cycle
// and pushes it into a two-entry command queue; the back sequencer pops
// it and runs it against the 16-entry table.
// Each accepted request is registered in the queue before the back pops
// it, only when idle. A packet is then looked up in parallel and updated;
// ignored and empty-query requests get their result when popped. A sweep
// or query walks the live entries, one table entry per cycle while the
// result register is free, through the sequencer's single read pointer.
// The result register holds each result until out_ready; while it waits
// the sequencer pauses and the queue keeps accepting until full.
// Reset empties the table and queue, clears the transaction id and sets
// evict_timeout (APB offset 0) to 20.
module peer_table_with_aging (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] now_seconds,
    input  logic [31:0] source_address,
    input  logic [7:0]  ip_protocol,
    input  logic [3:0]  header_words,
    input  logic [15:0] packet_length,
    input  logic [7:0]  message_type,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] peer_address,
    output logic [15:0] round_tag,
    output logic        last_of_run
);

    logic [15:0]       timeout_reg;
    logic              cfg_wr;
    logic              push_valid;
    logic              push_ready;
    ptwa_pkg::cmd_t    push_cmd;
    logic              q_valid;
    logic              q_pop;
    ptwa_pkg::cmd_t    q_cmd;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ptwa_pkg::REG_TIMEOUT);
    assign prdata = (paddr[2] == ptwa_pkg::REG_TIMEOUT) ? {16'b0, timeout_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= ptwa_pkg::TIMEOUT_RESET;
        else if (cfg_wr)
            timeout_reg <= pwdata[15:0];
    end

    ptwa_front u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .now_seconds    (now_seconds),
        .source_address (source_address),
        .ip_protocol    (ip_protocol),
        .header_words   (header_words),
        .packet_length  (packet_length),
        .message_type   (message_type),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_cmd       (push_cmd)
    );

    ptwa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    ptwa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .evict_timeout (timeout_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_cmd         (q_cmd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .peer_address  (peer_address),
        .round_tag     (round_tag),
        .last_of_run   (last_of_run)
    );

endmodule
